/* design/bsa_pkg.sv */
// bsa_pkg: shared types, codes and helpers for the bitmap slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package bsa_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = 6;
  localparam int WORD_W   = 32;
  localparam int GROUP_W  = 8;
  localparam int GROUPS   = 8;
  localparam int OCC_W    = GROUPS * GROUP_W;

  // Slots at or above SLOTS never count as free.
  localparam logic [OCC_W-1:0] SLOT_MASK =
    (SLOTS >= OCC_W) ? {OCC_W{1'b1}} : ((OCC_W'(1) << SLOTS) - OCC_W'(1));
  localparam logic [SLOT_W:0] SLOTS_EXT = (SLOT_W+1)'(SLOTS);

  // Request modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_CTRL  = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  // Request kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_TILE  = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_KIND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture request word
    logic scan;   // register per-group free flags
    logic exec;   // resolve request, update bitmap, drive result
  } bsa_cmd_t;

  // Index of the lowest set bit of an 8-bit vector (0 when empty).
  function automatic logic [2:0] lsb8(logic [GROUP_W-1:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

/* design/bitmap_slot_allocator.sv */
// bitmap_slot_allocator: top level, joins the sequencer and the datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
`timescale 1ns / 1ps
// Slot allocator over a 64-entry occupancy bitmap, all slots free after reset.
// A request word (mode, kind, slot, word) is taken at a clock edge where
// start_i is high and busy_o is low. Every request gives exactly one result
// word, shown for a single cycle with done_o high once the request has passed
// through the scan and exec states. The receiver cannot stall it, so it must
// sample done_o every cycle. busy_o is high for one cycle after each accept,
// so a new request can be taken while the previous one is in exec: the scan
// state registers per-group free flags from the bitmap; the exec state picks the
// lowest free group and the lowest free bit inside it, updates the bitmap and
// registers the result. Because the bitmap update lands on the edge where
// the next request is taken, back-to-back allocations
// always see each other. Modes: allocate returns the lowest free slot and a
// control write of word (or status "full"); control writes word to the named
// slot; free clears the slot's bit and writes zero. Kinds other than pixel or
// tile are rejected with no side effect; out-of-range slots report a range
// error and perform nothing. On any error result_slot_o, reg_write_o and
// reg_value_o are zero.
module bitmap_slot_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    mode_i,
  input  logic [1:0]                    kind_i,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_i,
  input  logic [bsa_pkg::WORD_W-1:0]    word_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [bsa_pkg::SLOT_W-1:0]    result_slot_o,
  output logic                          reg_write_o,
  output logic [bsa_pkg::WORD_W-1:0]    reg_value_o
);
  import bsa_pkg::*;

  bsa_cmd_t cmd;

  // sequencer: idle / scan / exec
  bsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  // bitmap, search and result register
  bsa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (mode_i),
    .kind_i       (kind_i),
    .slot_i       (slot_i),
    .word_i       (word_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .result_slot_o(result_slot_o),
    .reg_write_o  (reg_write_o),
    .reg_value_o  (reg_value_o)
  );

endmodule

/* design/bsa_ctrl.sv */
// bsa_ctrl: request sequencer of the bitmap slot allocator.
// Depends on bsa_pkg for the command struct.
`timescale 1ns / 1ps
module bsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output bsa_pkg::bsa_cmd_t cmd_o
);
  import bsa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        // next word may enter while this one resolves
        state_d = start_i ? S_SCAN : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o     = (state_q == S_SCAN);
  assign cmd_o.load = start_i && !busy_o;
  assign cmd_o.scan = (state_q == S_SCAN);
  assign cmd_o.exec = (state_q == S_EXEC);

endmodule

/* design/bsa_datapath.sv */
// bsa_datapath: occupancy bitmap, two-level first-free search and result register.
// Depends on bsa_pkg for codes, constants and the command struct.
`timescale 1ns / 1ps
module bsa_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsa_pkg::bsa_cmd_t             cmd_i,
  input  logic [1:0]                    mode_i,
  input  logic [1:0]                    kind_i,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_i,
  input  logic [bsa_pkg::WORD_W-1:0]    word_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [bsa_pkg::SLOT_W-1:0]    result_slot_o,
  output logic                          reg_write_o,
  output logic [bsa_pkg::WORD_W-1:0]    reg_value_o
);
  import bsa_pkg::*;

  // request word
  logic [1:0]        mode_q, kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WORD_W-1:0] word_q;

  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [GROUPS-1:0] grp_free_q, grp_free_d;

  logic              done_q;
  logic [1:0]        status_q, status_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic              wr_q, wr_d;
  logic [WORD_W-1:0] val_q, val_d;

  logic [2:0]         grp_sel, bit_sel;
  logic [GROUP_W-1:0] grp_avail;
  logic [SLOT_W-1:0]  alloc_idx;
  logic               in_range;

  // first level: one free flag per group of eight slots
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_free_d[g] = |(~occ_q[g*GROUP_W +: GROUP_W] & SLOT_MASK[g*GROUP_W +: GROUP_W]);
    end
  end

  // second level: lowest free group, then lowest free bit inside it
  assign grp_sel   = lsb8(grp_free_q);
  assign grp_avail = ~occ_q[{grp_sel, 3'b000} +: GROUP_W]
                     & SLOT_MASK[{grp_sel, 3'b000} +: GROUP_W];
  assign bit_sel   = lsb8(grp_avail);
  assign alloc_idx = {grp_sel, bit_sel};
  assign in_range  = {1'b0, slot_q} < SLOTS_EXT;

  always_comb begin
    occ_d    = occ_q;
    status_d = ST_OK;
    rslot_d  = '0;
    wr_d     = 1'b0;
    val_d    = '0;
    if (kind_q != KIND_PIXEL && kind_q != KIND_TILE) begin
      status_d = ST_BAD_KIND;
    end else begin
      case (mode_q)
        MODE_ALLOC: begin
          if (grp_free_q == '0) begin
            status_d = ST_FULL;
          end else begin
            occ_d[alloc_idx] = 1'b1;
            rslot_d          = alloc_idx;
            wr_d             = 1'b1;
            val_d            = word_q;
          end
        end
        MODE_CTRL: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            rslot_d = slot_q;
            wr_d    = 1'b1;
            val_d   = word_q;
          end
        end
        MODE_FREE: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            occ_d[slot_q] = 1'b0;
            rslot_d       = slot_q;
            wr_d          = 1'b1;
          end
        end
        default: begin
          // unused mode: no operation
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      kind_q <= kind_i;
      slot_q <= slot_i;
      word_q <= word_i;
    end
    if (cmd_i.scan) grp_free_q <= grp_free_d;
    if (cmd_i.exec) begin
      status_q <= status_d;
      rslot_q  <= rslot_d;
      wr_q     <= wr_d;
      val_q    <= val_d;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_slot_o = rslot_q;
  assign reg_write_o   = wr_q;
  assign reg_value_o   = val_q;

endmodule

/* design/bsa_checker.sv */
// bsa_checker: port-level timing and result checks for the slot allocator.
// Depends on bsa_pkg; bound to bitmap_slot_allocator below.
`timescale 1ns / 1ps
module bsa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_o,
  input  logic                          done_o,
  input  logic [1:0]                    status_o,
  input  logic [bsa_pkg::SLOT_W-1:0]    result_slot_o,
  input  logic                          reg_write_o,
  input  logic [bsa_pkg::WORD_W-1:0]    reg_value_o
);
  import bsa_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accept did not raise busy");

  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 done_o)
    else $error("result not delivered three cycles after accept");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results on consecutive cycles");

  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |->
      !reg_write_o && reg_value_o == '0 && result_slot_o == '0)
    else $error("error result carries a write");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

/* dv/tb.sv */
// tb: self-checking bench for bitmap_slot_allocator, with a directed and a random request mix.
// Depends on bsa_pkg and the bitmap_slot_allocator RTL; it reads no files.
`timescale 1ns / 1ps
module tb;
  import bsa_pkg::*;

  // Mode and kinds that the package leaves unnamed
  localparam logic [1:0] MODE_NOP  = 2'd3;
  localparam logic [1:0] KIND_BAD2 = 2'd2;
  localparam logic [1:0] KIND_BAD3 = 2'd3;

  localparam int STALL_LIMIT = 1000;   // cycles with no accept and no result
  localparam int DRAIN_CYCLES = 8;     // margin after the last expected result

  typedef struct {
    logic [1:0]        mode;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    int                gap;   // idle cycles before this word is offered
  } req_t;

  typedef struct {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              wr;
    logic [WORD_W-1:0] value;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] mode_i = '0;
  logic [1:0] kind_i = '0;
  logic [SLOT_W-1:0] slot_i = '0;
  logic [WORD_W-1:0] word_i = '0;
  logic busy_o, done_o, reg_write_o;
  logic [1:0] status_o;
  logic [SLOT_W-1:0] result_slot_o;
  logic [WORD_W-1:0] reg_value_o;

  req_t  req_q[$];          // words waiting to be offered
  resp_t expected_resp[$];  // predicted results, oldest first
  logic [OCC_W-1:0] occ_model = '0;
  int gap_cnt = 0;
  int stall_cycles = 0;
  int errors = 0;

  bitmap_slot_allocator uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .kind_i, .slot_i, .word_i,
    .done_o, .status_o, .result_slot_o, .reg_write_o, .reg_value_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Allocator model: applies one accepted word to occ_model and returns its result.
  function automatic resp_t allocate_predict(logic [1:0] mode, logic [1:0] kind,
                                             logic [SLOT_W-1:0] slot,
                                             logic [WORD_W-1:0] word);
    resp_t r;
    logic [OCC_W-1:0] avail;
    int lowest;
    r = '{ST_OK, '0, 1'b0, '0};
    avail = ~occ_model & SLOT_MASK;
    lowest = -1;
    if (kind != KIND_PIXEL && kind != KIND_TILE) begin
      r.status = ST_BAD_KIND;
      return r;
    end
    case (mode)
      MODE_ALLOC: begin
        for (int i = OCC_W - 1; i >= 0; i--) begin
          if (avail[i]) lowest = i;
        end
        if (lowest < 0) begin
          r.status = ST_FULL;
        end else begin
          occ_model[lowest] = 1'b1;
          r = '{ST_OK, SLOT_W'(lowest), 1'b1, word};
        end
      end
      MODE_CTRL: begin
        if ({1'b0, slot} >= SLOTS_EXT) r.status = ST_RANGE;
        else r = '{ST_OK, slot, 1'b1, word};
      end
      MODE_FREE: begin
        if ({1'b0, slot} >= SLOTS_EXT) begin
          r.status = ST_RANGE;
        end else begin
          occ_model[slot] = 1'b0;
          r = '{ST_OK, slot, 1'b1, '0};
        end
      end
      default: ;  // unused mode: no operation
    endcase
    return r;
  endfunction

  function automatic void add_req(logic [1:0] mode, logic [1:0] kind,
                                  logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word,
                                  int gap);
    req_t r;
    r = '{mode, kind, slot, word, gap};
    req_q.push_back(r);
  endfunction

  // Driver: offers queued words, honoring each word's gap; holds while busy.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (start_i && !busy_o) begin
        expected_resp.push_back(allocate_predict(mode_i, kind_i, slot_i, word_i));
      end
      if (!start_i || !busy_o) begin
        if (req_q.size() == 0) begin
          start_i <= 1'b0;
        end else if (gap_cnt < req_q[0].gap) begin
          gap_cnt <= gap_cnt + 1;
          start_i <= 1'b0;
        end else begin
          mode_i  <= req_q[0].mode;
          kind_i  <= req_q[0].kind;
          slot_i  <= req_q[0].slot;
          word_i  <= req_q[0].word;
          start_i <= 1'b1;
          gap_cnt <= 0;
          void'(req_q.pop_front());
        end
      end
    end
  end

  // Monitor: a result shows for one cycle only, so done_o is sampled every edge.
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_resp.size() == 0) begin
          $error("unexpected result: status %0d slot %0d", status_o, result_slot_o);
          errors++;
        end else begin
          e = expected_resp.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errors++;
          end
          if (result_slot_o !== e.slot) begin
            $error("result_slot: expected %0d, got %0d", e.slot, result_slot_o);
            errors++;
          end
          if (reg_write_o !== e.wr) begin
            $error("reg_write: expected %0d, got %0d", e.wr, reg_write_o);
            errors++;
          end
          if (reg_value_o !== e.value) begin
            $error("reg_value: expected %h, got %h", e.value, reg_value_o);
            errors++;
          end
        end
      end
      // Watchdog: any accept or result counts as progress.
      if (done_o || (start_i && !busy_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int phase_len, phase_kind, pick;
    bit no_idle;
    logic [1:0] m, k;

    // Directed: both kinds, word and slot extremes, double free, control to an
    // unallocated slot, rejected kinds under every mode, the unused mode.
    add_req(MODE_ALLOC, KIND_PIXEL, '0, '0, 0);
    add_req(MODE_ALLOC, KIND_TILE, 6'd63, '1, 0);
    add_req(MODE_CTRL, KIND_PIXEL, '0, 32'hA5A5_A5A5, 1);
    add_req(MODE_CTRL, KIND_TILE, 6'd63, '1, 0);
    add_req(MODE_FREE, KIND_PIXEL, 6'd1, '1, 2);
    add_req(MODE_FREE, KIND_TILE, 6'd1, 32'h5A5A_5A5A, 0);
    add_req(MODE_ALLOC, KIND_TILE, 6'd17, 32'h8000_0001, 0);
    add_req(MODE_FREE, KIND_PIXEL, 6'd63, '0, 3);
    add_req(MODE_ALLOC, KIND_BAD2, 6'd5, 32'h1234_5678, 0);
    add_req(MODE_CTRL, KIND_BAD3, 6'd2, '1, 0);
    add_req(MODE_FREE, KIND_BAD2, 6'd0, '1, 5);
    add_req(MODE_NOP, KIND_BAD3, 6'd63, '1, 0);
    add_req(MODE_NOP, KIND_PIXEL, 6'd0, '0, 0);
    add_req(MODE_NOP, KIND_TILE, 6'd63, '1, 4);
    add_req(MODE_FREE, KIND_TILE, 6'd0, '0, 0);
    add_req(MODE_ALLOC, KIND_PIXEL, 6'd42, 32'h7FFF_FFFF, 0);

    // Random: phases that fill, drain or mix the bitmap, so the full case and
    // frees of both used and free slots come up repeatedly.
    while (req_q.size() < 1516) begin
      phase_len = $urandom_range(40, 150);
      phase_kind = $urandom_range(0, 2);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        case (phase_kind)
          0: m = (pick < 80) ? MODE_ALLOC : (pick < 90) ? MODE_CTRL : MODE_FREE;
          1: m = (pick < 20) ? MODE_ALLOC : (pick < 35) ? MODE_CTRL : MODE_FREE;
          default: m = (pick < 40) ? MODE_ALLOC : (pick < 65) ? MODE_CTRL : MODE_FREE;
        endcase
        if ($urandom_range(0, 19) == 0) m = MODE_NOP;
        k = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                        : 2'($urandom_range(0, 1));
        add_req(m, k, SLOT_W'($urandom_range(0, SLOTS - 1)), $urandom,
                no_idle ? 0 : $urandom_range(0, 5));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || start_i || expected_resp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && expected_resp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
